@@ design/umsdp_pkg.sv @@
// Package for the USB mass storage descriptor parser.
// Shared constants, codes and structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package umsdp_pkg;

   // Configuration header bytes skipped ahead of the first descriptor
   localparam int HEADER_BYTES = 9;
   localparam int HDR_CNT_WIDTH = $clog2(HEADER_BYTES + 2);

   // APB register map
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [1:0] REG_MATCH_CLASS    = 2'd0;
   localparam logic [1:0] REG_MATCH_SUBCLASS = 2'd1;
   localparam logic [1:0] REG_MATCH_PROTOCOL = 2'd2;

   localparam logic [7:0] RESET_CLASS    = 8'd8;
   localparam logic [7:0] RESET_SUBCLASS = 8'd6;
   localparam logic [7:0] RESET_PROTOCOL = 8'd80;

   // Descriptor types and field positions
   localparam logic [7:0] TYPE_INTERFACE = 8'd4;
   localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
   localparam logic [7:0] POS_LENGTH     = 8'd0;
   localparam logic [7:0] POS_TYPE       = 8'd1;
   localparam logic [7:0] POS_IFACE_NUM  = 8'd2;
   localparam logic [7:0] POS_NUM_EPS    = 8'd4;
   localparam logic [7:0] POS_CLASS      = 8'd5;
   localparam logic [7:0] POS_SUBCLASS   = 8'd6;
   localparam logic [7:0] POS_PROTOCOL   = 8'd7;
   localparam logic [7:0] POS_EP_ADDR    = 8'd2;
   localparam logic [7:0] POS_EP_ATTR    = 8'd3;
   localparam logic [7:0] IFACE_MIN_LEN  = 8'd8;
   localparam logic [7:0] EP_MIN_LEN     = 8'd4;

   localparam logic [7:0] XFER_MASK = 8'h03;
   localparam logic [7:0] XFER_BULK = 8'h02;
   localparam int         DIR_IN_BIT = 7;
   localparam logic [2:0] FIELDS_ALL = 3'b111;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH  = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   typedef enum logic [3:0] {
      MODE_SEARCH    = 4'b0001,
      MODE_ENDPOINTS = 4'b0010,
      MODE_DONE      = 4'b0100,
      MODE_BAD       = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] match_class;
      logic [7:0] match_subclass;
      logic [7:0] match_protocol;
   } match_cfg_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] interface_number;
      logic [7:0] bulk_in_address;
      logic [7:0] bulk_out_address;
   } result_type;

endpackage

`default_nettype wire

@@ design/umsdp_if.sv @@
// Channel interfaces for the descriptor parser: byte input and result output.
// Depends on nothing; payload widths follow the byte and result fields.
`timescale 1ns / 1ps
`default_nettype none

interface umsdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface umsdp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] interface_number;
   logic [7:0] bulk_in_address;
   logic [7:0] bulk_out_address;

   modport source (output valid, output status, output interface_number,
                   output bulk_in_address, output bulk_out_address, input ready);
   modport sink   (input valid, input status, input interface_number,
                   input bulk_in_address, input bulk_out_address, output ready);
endinterface

`default_nettype wire

@@ design/umsdp_csr.sv @@
// APB register block holding the interface match codes.
// Depends on umsdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module umsdp_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [umsdp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [umsdp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [umsdp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                       csr_pready,
   output umsdp_pkg::match_cfg_type                   match_cfg
);
   import umsdp_pkg::*;

   match_cfg_type cfg_ff;
   logic          wr_en;
   logic [1:0]    reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign match_cfg  = cfg_ff;

   // Register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_class    <= RESET_CLASS;
         cfg_ff.match_subclass <= RESET_SUBCLASS;
         cfg_ff.match_protocol <= RESET_PROTOCOL;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MATCH_CLASS:    cfg_ff.match_class    <= csr_pwdata[7:0];
            REG_MATCH_SUBCLASS: cfg_ff.match_subclass <= csr_pwdata[7:0];
            REG_MATCH_PROTOCOL: cfg_ff.match_protocol <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_MATCH_CLASS:    csr_prdata[7:0] = cfg_ff.match_class;
         REG_MATCH_SUBCLASS: csr_prdata[7:0] = cfg_ff.match_subclass;
         REG_MATCH_PROTOCOL: csr_prdata[7:0] = cfg_ff.match_protocol;
         default:            csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ design/umsdp_parser.sv @@
// Descriptor walk state and per-byte update; forms the result on the last byte.
// Depends on umsdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module umsdp_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      byte_take,
   input  wire logic [7:0]                data_byte,
   input  wire logic                      last_byte,
   input  umsdp_pkg::match_cfg_type       match_cfg,
   output logic                           result_push,
   output umsdp_pkg::result_type          result
);
   import umsdp_pkg::*;

   logic [HDR_CNT_WIDTH-1:0] header_left_ff, header_left_in;
   logic [7:0]               byte_idx_ff, byte_idx_in;
   logic [7:0]               desc_size_ff, desc_size_in;
   logic [7:0]               desc_type_ff, desc_type_in;
   logic [2:0]               field_match_ff, field_match_in;
   logic [7:0]               iface_ff, iface_in;
   logic [7:0]               eps_left_ff, eps_left_in;
   logic [7:0]               ep_attr_ff, ep_attr_in;
   logic [7:0]               ep_addr_ff, ep_addr_in;
   mode_type                 mode_ff, mode_in;
   logic [7:0]               found_in_ff, found_in_in;
   logic [7:0]               found_out_ff, found_out_in;
   logic                     searching;
   logic                     walking;

   assign searching = (mode_ff == MODE_SEARCH);
   assign walking   = (mode_ff == MODE_SEARCH) || (mode_ff == MODE_ENDPOINTS);

   always_comb begin
      header_left_in = header_left_ff;
      byte_idx_in    = byte_idx_ff;
      desc_size_in   = desc_size_ff;
      desc_type_in   = desc_type_ff;
      field_match_in = field_match_ff;
      iface_in       = iface_ff;
      eps_left_in    = eps_left_ff;
      ep_attr_in     = ep_attr_ff;
      ep_addr_in     = ep_addr_ff;
      mode_in        = mode_ff;
      found_in_in    = found_in_ff;
      found_out_in   = found_out_ff;

      if (byte_take) begin
         if (header_left_ff != '0) begin
            header_left_in = header_left_ff - HDR_CNT_WIDTH'(1);
         end else if (walking) begin
            if (byte_idx_ff == POS_LENGTH && data_byte == 8'd0) begin
               // zero length would never advance: flag the set as malformed
               if (searching) iface_in = 8'd0;
               mode_in = MODE_BAD;
            end else begin
               // capture the fields of the current descriptor
               if (byte_idx_ff == POS_LENGTH) begin
                  desc_size_in   = data_byte;
                  desc_type_in   = 8'd0;
                  field_match_in = 3'd0;
                  ep_attr_in     = 8'd0;
                  ep_addr_in     = 8'd0;
                  if (searching) eps_left_in = 8'd0;
               end else if (byte_idx_ff == POS_TYPE) begin
                  desc_type_in = data_byte;
               end else if (searching && desc_type_ff == TYPE_INTERFACE) begin
                  if (byte_idx_ff == POS_IFACE_NUM) iface_in = data_byte;
                  else if (byte_idx_ff == POS_NUM_EPS) eps_left_in = data_byte;
                  else if (byte_idx_ff == POS_CLASS && data_byte == match_cfg.match_class)
                     field_match_in[0] = 1'b1;
                  else if (byte_idx_ff == POS_SUBCLASS &&
                           data_byte == match_cfg.match_subclass)
                     field_match_in[1] = 1'b1;
                  else if (byte_idx_ff == POS_PROTOCOL &&
                           data_byte == match_cfg.match_protocol)
                     field_match_in[2] = 1'b1;
               end else if (!searching && desc_type_ff == TYPE_ENDPOINT) begin
                  if (byte_idx_ff == POS_EP_ADDR) ep_addr_in = data_byte;
                  else if (byte_idx_ff == POS_EP_ATTR) ep_attr_in = data_byte;
               end

               // judge the descriptor once its final byte is in
               if (({1'b0, byte_idx_ff} + 9'd1) >= {1'b0, desc_size_in}) begin
                  byte_idx_in = 8'd0;
                  if (searching) begin
                     if (desc_type_in == TYPE_INTERFACE && field_match_in == FIELDS_ALL &&
                         desc_size_in >= IFACE_MIN_LEN)
                        mode_in = (eps_left_in == 8'd0) ? MODE_DONE : MODE_ENDPOINTS;
                  end else begin
                     if (desc_type_in == TYPE_ENDPOINT && desc_size_in >= EP_MIN_LEN &&
                         (ep_attr_in & XFER_MASK) == XFER_BULK) begin
                        if (ep_addr_in[DIR_IN_BIT]) found_in_in  = ep_addr_in;
                        else                        found_out_in = ep_addr_in;
                     end
                     eps_left_in = eps_left_in - 8'd1;
                     if (eps_left_in == 8'd0) mode_in = MODE_DONE;
                  end
               end else begin
                  byte_idx_in = byte_idx_ff + 8'd1;
               end
            end
         end
      end

      // result from the state after this byte
      result_push = byte_take && last_byte;
      if (mode_in == MODE_BAD)
         result.status = STATUS_MALFORMED;
      else if (found_in_in != 8'd0 && found_out_in != 8'd0)
         result.status = STATUS_OK;
      else
         result.status = STATUS_NO_MATCH;
      result.interface_number = (mode_in == MODE_SEARCH) ? 8'd0 : iface_in;
      result.bulk_in_address  = found_in_in;
      result.bulk_out_address = found_out_in;
   end

   // State registers; the last byte restarts the walk
   always_ff @(posedge clock) begin
      if (reset || result_push) begin
         header_left_ff <= HDR_CNT_WIDTH'(HEADER_BYTES);
         byte_idx_ff    <= 8'd0;
         desc_size_ff   <= 8'd0;
         desc_type_ff   <= 8'd0;
         field_match_ff <= 3'd0;
         iface_ff       <= 8'd0;
         eps_left_ff    <= 8'd0;
         ep_attr_ff     <= 8'd0;
         ep_addr_ff     <= 8'd0;
         mode_ff        <= MODE_SEARCH;
         found_in_ff    <= 8'd0;
         found_out_ff   <= 8'd0;
      end else begin
         header_left_ff <= header_left_in;
         byte_idx_ff    <= byte_idx_in;
         desc_size_ff   <= desc_size_in;
         desc_type_ff   <= desc_type_in;
         field_match_ff <= field_match_in;
         iface_ff       <= iface_in;
         eps_left_ff    <= eps_left_in;
         ep_attr_ff     <= ep_attr_in;
         ep_addr_ff     <= ep_addr_in;
         mode_ff        <= mode_in;
         found_in_ff    <= found_in_in;
         found_out_ff   <= found_out_in;
      end
   end

endmodule

`default_nettype wire

@@ design/umsdp_rsp_buf.sv @@
// Result output register with a skid entry so input keeps flowing under stall.
// Depends on umsdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module umsdp_rsp_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  umsdp_pkg::result_type  push_data,
   output logic                   accept_ok,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output umsdp_pkg::result_type  out_data
);
   import umsdp_pkg::*;

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_data_ff;
   result_type skid_data_ff;
   logic       pop;

   assign pop       = out_valid_ff && out_ready;
   assign accept_ok = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Control: skid fills only when the output register is held
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (out_valid_ff && !pop) skid_valid_ff <= 1'b1;
         else                      out_valid_ff  <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) out_data_ff <= skid_data_ff;
      end else if (push) begin
         if (out_valid_ff && !pop) skid_data_ff <= push_data;
         else                      out_data_ff  <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ design/usb_mass_storage_descriptor_parser.sv @@
// USB mass storage descriptor parser, top level.
// Depends on umsdp_pkg, umsdp_if, umsdp_csr, umsdp_parser, umsdp_rsp_buf.
`timescale 1ns / 1ps
`default_nettype none

// Takes a configuration descriptor set one byte per transfer and, on the byte
// flagged last, returns one result: the number of the first interface whose
// class/subclass/protocol match the CSR values, and its bulk IN/OUT endpoint
// addresses. One byte is taken every clock unless req stalls; the per-byte walk
// is combinational on the parser state registers; the result is registered in
// the two-entry output stage (output register plus skid), which keeps req
// ready while one result waits, so req stalls only when two results are
// pending. Match codes are written through the APB port at byte offsets 0, 4
// and 8; the user must do so only while the block is idle (not enforced).

module usb_mass_storage_descriptor_parser (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   umsdp_req_if.sink                                  req,
   umsdp_rsp_if.source                                rsp,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [umsdp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [umsdp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [umsdp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                       csr_pready
);
   import umsdp_pkg::*;

   match_cfg_type match_cfg;
   result_type    result;
   result_type    rsp_data;
   logic          result_push;
   logic          accept_ok;
   logic          byte_take;

   assign req.ready = accept_ok;
   assign byte_take = req.valid && accept_ok;

   umsdp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .match_cfg   (match_cfg)
   );

   umsdp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_take   (byte_take),
      .data_byte   (req.data_byte),
      .last_byte   (req.last_byte),
      .match_cfg   (match_cfg),
      .result_push (result_push),
      .result      (result)
   );

   umsdp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .accept_ok (accept_ok),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp_data)
   );

   assign rsp.status           = rsp_data.status;
   assign rsp.interface_number = rsp_data.interface_number;
   assign rsp.bulk_in_address  = rsp_data.bulk_in_address;
   assign rsp.bulk_out_address = rsp_data.bulk_out_address;

endmodule

`default_nettype wire
